[rtl/core/mlfp_pkg.sv]
// Package for the length-prefixed frame parser: result and config structs,
// codes and header constants. Depends on nothing.
`default_nettype none
package mlfp_pkg;

	// Width of the length field that the design accepts (8..32).
	localparam int LENGTH_BITS = 32;

	// Header layout: marker bytes, then id bytes, then length bytes.
	localparam int MARKER_BYTES = 4;
	localparam int ID_BYTES     = 2;
	localparam int HDR_BYTES    = MARKER_BYTES + ID_BYTES + 4;
	localparam int HC_W         = 4;

	localparam logic [HC_W-1:0] HC_ID_LO  = HC_W'(MARKER_BYTES);
	localparam logic [HC_W-1:0] HC_ID_HI  = HC_W'(MARKER_BYTES + 1);
	localparam logic [HC_W-1:0] HC_LEN_B0 = HC_W'(MARKER_BYTES + ID_BYTES);
	localparam logic [HC_W-1:0] HC_LEN_B1 = HC_W'(MARKER_BYTES + ID_BYTES + 1);
	localparam logic [HC_W-1:0] HC_LEN_B2 = HC_W'(MARKER_BYTES + ID_BYTES + 2);
	localparam logic [HC_W-1:0] HC_LAST   = HC_W'(HDR_BYTES - 1);

	// Upper bound that the length field width itself puts on a length.
	localparam logic [31:0] LEN_CAP = (LENGTH_BITS >= 31) ? 32'h7FFF_FFFF :
		32'((64'd1 << LENGTH_BITS) - 64'd1);

	// Register reset values.
	localparam logic [31:0] MARKER_RESET = 32'h4642_4542;
	localparam logic [30:0] MAXLEN_RESET = 31'd65536;

	// Register indexes, taken from paddr[2].
	localparam logic REG_IDX_MARKER = 1'b0;
	localparam logic REG_IDX_MAXLEN = 1'b1;

	// Operation carried in s_tuser.
	localparam logic OP_BYTE          = 1'b0;
	localparam logic OP_SESSION_RESET = 1'b1;

	typedef enum logic [1:0] {
		KIND_PAYLOAD    = 2'd0,
		KIND_BAD_MARKER = 2'd1,
		KIND_BAD_LENGTH = 2'd2,
		KIND_REFUSED    = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		PH_HEADER  = 3'b001,
		PH_PAYLOAD = 3'b010,
		PH_AWAIT   = 3'b100
	} phase_t;

	// One result word as it travels from the front through the queue.
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  payload_byte;
		logic [15:0] event_id;
		logic        last;
	} res_t;

	// Configuration seen by the front part.
	typedef struct packed {
		logic [31:0] frame_marker;
		logic [30:0] max_payload_len;
	} cfg_t;

	// Queue status toward the front and the top level.
	typedef struct packed {
		logic full;
		logic not_empty;
	} q_status_t;

endpackage
`default_nettype wire

[rtl/core/mlfp_front.sv]
// Front part of the frame parser: accepts bytes, tracks header, payload and
// await phases and classifies each byte into a result word. Uses mlfp_pkg.
`default_nettype none
module mlfp_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire mlfp_pkg::cfg_t  cfg,
	input  wire logic            accept,
	input  wire logic            operation,
	input  wire logic [7:0]      stream_byte,
	output mlfp_pkg::res_t       res,
	output logic                 push
);

	mlfp_pkg::phase_t             phase_q;
	logic [mlfp_pkg::HC_W-1:0]    header_count_q;
	logic [31:0]                  marker_shift_q;
	logic [15:0]                  event_id_q;
	logic [31:0]                  payload_length_q;
	logic [31:0]                  payload_count_q;

	logic [31:0] count_inc;
	logic        fin;
	logic [31:0] len_full;
	logic        marker_bad;
	logic        length_bad;

	// Payload bookkeeping: the count after this byte and the final-byte test.
	assign count_inc = payload_count_q + 32'd1;
	assign fin       = (count_inc >= payload_length_q);

	// Header checks on the tenth byte, which carries the top length byte.
	assign len_full   = {stream_byte, payload_length_q[23:0]};
	assign marker_bad = (marker_shift_q != cfg.frame_marker);
	assign length_bad = len_full[31] || (len_full == 32'd0) ||
		(len_full > {1'b0, cfg.max_payload_len}) || (len_full > mlfp_pkg::LEN_CAP);

	// Result word for the accepted byte.
	always_comb begin
		push             = 1'b0;
		res.kind         = mlfp_pkg::KIND_PAYLOAD;
		res.payload_byte = 8'd0;
		res.event_id     = event_id_q;
		res.last         = 1'b0;
		if (accept && operation == mlfp_pkg::OP_BYTE) begin
			unique case (phase_q)
				mlfp_pkg::PH_AWAIT: begin
					push     = 1'b1;
					res.kind = mlfp_pkg::KIND_REFUSED;
				end
				mlfp_pkg::PH_PAYLOAD: begin
					push             = 1'b1;
					res.payload_byte = stream_byte;
					res.last         = fin;
				end
				default: begin
					if (header_count_q == mlfp_pkg::HC_LAST) begin
						if (marker_bad) begin
							push     = 1'b1;
							res.kind = mlfp_pkg::KIND_BAD_MARKER;
						end else if (length_bad) begin
							push     = 1'b1;
							res.kind = mlfp_pkg::KIND_BAD_LENGTH;
						end
					end
				end
			endcase
		end
	end

	// Parser state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= mlfp_pkg::PH_HEADER;
			header_count_q   <= '0;
			marker_shift_q   <= '0;
			event_id_q       <= '0;
			payload_length_q <= '0;
			payload_count_q  <= '0;
		end else if (accept) begin
			if (operation == mlfp_pkg::OP_SESSION_RESET) begin
				// A session reset keeps the event id.
				phase_q          <= mlfp_pkg::PH_HEADER;
				header_count_q   <= '0;
				marker_shift_q   <= '0;
				payload_length_q <= '0;
				payload_count_q  <= '0;
			end else begin
				unique case (phase_q)
					mlfp_pkg::PH_AWAIT: begin
					end
					mlfp_pkg::PH_PAYLOAD: begin
						if (fin) begin
							phase_q         <= mlfp_pkg::PH_AWAIT;
							payload_count_q <= '0;
						end else begin
							payload_count_q <= count_inc;
						end
					end
					default: begin
						if (header_count_q == mlfp_pkg::HC_LAST) begin
							// Tenth byte: restart on a bad header, else enter the payload.
							header_count_q  <= '0;
							payload_count_q <= '0;
							if (marker_bad || length_bad) begin
								phase_q          <= mlfp_pkg::PH_HEADER;
								marker_shift_q   <= '0;
								payload_length_q <= '0;
							end else begin
								phase_q                 <= mlfp_pkg::PH_PAYLOAD;
								payload_length_q[31:24] <= stream_byte;
							end
						end else begin
							header_count_q <= header_count_q + 1'b1;
							case (header_count_q) inside
								[4'd0:4'd3]: begin
									marker_shift_q <= {marker_shift_q[23:0], stream_byte};
								end
								mlfp_pkg::HC_ID_LO: begin
									event_id_q <= {8'd0, stream_byte};
								end
								mlfp_pkg::HC_ID_HI: begin
									event_id_q[15:8] <= stream_byte;
								end
								mlfp_pkg::HC_LEN_B0: begin
									payload_length_q <= {24'd0, stream_byte};
								end
								mlfp_pkg::HC_LEN_B1: begin
									payload_length_q[15:8] <= stream_byte;
								end
								mlfp_pkg::HC_LEN_B2: begin
									payload_length_q[23:16] <= stream_byte;
								end
								default: begin
								end
							endcase
						end
					end
				endcase
			end
		end
	end

endmodule
`default_nettype wire

[rtl/core/mlfp_queue.sv]
// Two-entry queue of result words between the front and back parts.
// Uses mlfp_pkg for the result word and status types.
`default_nettype none
module mlfp_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire mlfp_pkg::res_t      wr_data,
	input  wire logic                pop,
	output mlfp_pkg::res_t           rd_data,
	output mlfp_pkg::q_status_t      status
);

	mlfp_pkg::res_t slot_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;

	assign rd_data          = slot_q[rd_ptr_q];
	assign status.full      = (count_q == 2'd2);
	assign status.not_empty = (count_q != 2'd0);

	// Entry storage needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

[rtl/core/mlfp_back.sv]
// Back part of the frame parser: output register that drives the result
// stream from the queue. Uses mlfp_pkg for the result word.
`default_nettype none
module mlfp_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            q_valid,
	input  wire mlfp_pkg::res_t  q_data,
	output logic                 pop,
	output logic                 m_tvalid,
	input  wire logic            m_tready,
	output logic [23:0]          m_tdata,
	output logic [1:0]           m_tuser,
	output logic                 m_tlast
);

	logic           valid_q;
	mlfp_pkg::res_t res_q;

	// Load the next word whenever the register is empty or being emptied.
	assign pop = q_valid && (!valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= q_data;
		end
	end

	// Pack the result word onto the stream.
	assign m_tvalid = valid_q;
	assign m_tdata  = {res_q.event_id, res_q.payload_byte};
	assign m_tuser  = res_q.kind;
	assign m_tlast  = res_q.last;

endmodule
`default_nettype wire

[rtl/core/magic_length_frame_parser_core.sv]
// Top level of the length-prefixed frame parser: configuration registers,
// front, queue and back parts. Uses mlfp_pkg, mlfp_front, mlfp_queue, mlfp_back.
//
//   channel  direction  fields (lowest bit first)
//   s_*      in         tdata: stream_byte[7:0]; tuser: operation
//   m_*      out        tdata: payload_byte[7:0], event_id[23:8]; tuser: kind;
//                       tlast: last
//   apb      in         0x0 frame_marker, 0x4 max_payload_len (paddr[2] selects)
//
// One byte is accepted every cycle while s_tready is high; its result, if any,
// passes through the queue slot and then the output register before it leaves.
// Reset is asynchronous and active low; control and configuration registers return to their defaults.
// s_tready drops only when the two-word queue is full while the output stalls.
`default_nettype none
module magic_length_frame_parser_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input stream. tdata: stream_byte. tuser: operation.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,
	input  wire logic        s_tuser,
	// Result stream. tdata: payload_byte[7:0], event_id[23:8]. tuser: kind.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,
	output logic [1:0]       m_tuser,
	output logic             m_tlast,
	// Configuration port.
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	mlfp_pkg::cfg_t      cfg_q;
	mlfp_pkg::res_t      f_res;
	mlfp_pkg::res_t      q_res;
	mlfp_pkg::q_status_t q_stat;
	logic                f_push;
	logic                q_pop;
	logic                s_accept;
	logic                cfg_wr;

	// Configuration registers.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_marker    <= mlfp_pkg::MARKER_RESET;
			cfg_q.max_payload_len <= mlfp_pkg::MAXLEN_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				mlfp_pkg::REG_IDX_MARKER: cfg_q.frame_marker    <= pwdata;
				mlfp_pkg::REG_IDX_MAXLEN: cfg_q.max_payload_len <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			mlfp_pkg::REG_IDX_MARKER: prdata = cfg_q.frame_marker;
			mlfp_pkg::REG_IDX_MAXLEN: prdata = {1'b0, cfg_q.max_payload_len};
			default:                  prdata = 32'd0;
		endcase
	end

	// Input handshake: a byte is taken whenever the queue has room.
	assign s_tready = !q_stat.full;
	assign s_accept = s_tvalid && s_tready;

	mlfp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.accept      (s_accept),
		.operation   (s_tuser),
		.stream_byte (s_tdata),
		.res         (f_res),
		.push        (f_push)
	);

	mlfp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (f_push),
		.wr_data (f_res),
		.pop     (q_pop),
		.rd_data (q_res),
		.status  (q_stat)
	);

	mlfp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_stat.not_empty),
		.q_data   (q_res),
		.pop      (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// Only payload words may mark the end of a frame.
	a_last_is_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (m_tuser == mlfp_pkg::KIND_PAYLOAD))
		else $error("tlast on a non-payload result");

	// Error and refused words carry a zero payload byte.
	a_err_zero_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser != mlfp_pkg::KIND_PAYLOAD)) |-> (m_tdata[7:0] == 8'd0))
		else $error("non-payload result with nonzero byte");

	// The back part never pops an empty queue.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_stat.not_empty)
		else $error("pop from empty queue");

	// The front part never pushes into a full queue.
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		f_push |-> !q_stat.full)
		else $error("push into full queue");

endmodule
`default_nettype wire
